/* hw/rtl/sle_pkg.sv */
// Package for the string literal escaper: character codes, the escape
// sequence type and helper functions. No dependencies.
`timescale 1ns / 1ps

package sle_pkg;

	// Longest sequence for one request: opening quote plus a hex escape
	localparam int unsigned MaxChars = 5;
	localparam int unsigned CountW   = 3;

	// Printable range bounds
	localparam logic [7:0] FirstPrintable = 8'd32;
	localparam logic [7:0] DelCode        = 8'd127;

	// Opcodes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Character codes
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LOWA   = 8'h61;

	// Control codes with letter escapes
	localparam logic [7:0] C_BEL = 8'd7;
	localparam logic [7:0] C_BS  = 8'd8;
	localparam logic [7:0] C_TAB = 8'd9;
	localparam logic [7:0] C_LF  = 8'd10;
	localparam logic [7:0] C_VT  = 8'd11;
	localparam logic [7:0] C_FF  = 8'd12;
	localparam logic [7:0] C_CR  = 8'd13;

	typedef logic [7:0] char_t;

	// Output sequence for one request, first character at index 0
	typedef struct packed {
		char_t [MaxChars-1:0] chars;
		logic [CountW-1:0]    count;
		logic                 is_end;
	} seq_t;

	// Lowercase hex digit of a nibble
	function automatic char_t hex_digit(input logic [3:0] v);
		char_t r;
		if (v < 4'd10) begin
			r = CH_ZERO + {4'd0, v};
		end else begin
			r = CH_LOWA + {4'd0, v} - 8'd10;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/sle_in_if.sv */
// Request channel of the escaper: opcode and raw byte, valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps

interface sle_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

/* hw/rtl/sle_out_if.sv */
// Result channel of the escaper: one literal character per handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface sle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_last;
	logic       literal_done;

	modport source (output valid, output out_char, output run_last, output literal_done,
		input ready);
	modport sink   (input valid, input out_char, input run_last, input literal_done,
		output ready);
endinterface

/* hw/rtl/sle_encoder.sv */
// Escape encoder: maps one request and the open-literal flag to the
// characters it produces. Combinational. Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_encoder (
	input  logic           opcode,
	input  logic [7:0]     data_byte,
	input  logic           lit_open,
	output sle_pkg::seq_t  seq
);

	sle_pkg::char_t [3:0] body;
	logic [2:0]           body_len;
	sle_pkg::char_t       letter;
	logic                 has_letter;

	// Letter escapes for the named control codes
	always_comb begin
		has_letter = 1'b1;
		unique case (data_byte)
			sle_pkg::C_BEL: letter = 8'h61; // a
			sle_pkg::C_BS:  letter = 8'h62; // b
			sle_pkg::C_FF:  letter = 8'h66; // f
			sle_pkg::C_LF:  letter = 8'h6e; // n
			sle_pkg::C_CR:  letter = 8'h72; // r
			sle_pkg::C_TAB: letter = 8'h74; // t
			sle_pkg::C_VT:  letter = 8'h76; // v
			default: begin
				letter     = 8'h00;
				has_letter = 1'b0;
			end
		endcase
	end

	// Body of the sequence, without the opening quote
	always_comb begin
		body     = '0;
		body_len = 3'd1;
		if (opcode == sle_pkg::OP_END) begin
			body[0] = sle_pkg::CH_DQUOTE;
		end else if (data_byte == sle_pkg::CH_DQUOTE || data_byte == sle_pkg::CH_SQUOTE ||
			data_byte == sle_pkg::CH_BSLASH) begin
			body[0]  = sle_pkg::CH_BSLASH;
			body[1]  = data_byte;
			body_len = 3'd2;
		end else if (has_letter) begin
			body[0]  = sle_pkg::CH_BSLASH;
			body[1]  = letter;
			body_len = 3'd2;
		end else if (data_byte >= sle_pkg::FirstPrintable && data_byte < sle_pkg::DelCode) begin
			body[0] = data_byte;
		end else begin
			// other controls, DEL and high bytes: \xHH
			body[0]  = sle_pkg::CH_BSLASH;
			body[1]  = sle_pkg::CH_X;
			body[2]  = sle_pkg::hex_digit(data_byte[7:4]);
			body[3]  = sle_pkg::hex_digit(data_byte[3:0]);
			body_len = 3'd4;
		end
	end

	// Prepend the opening quote when no literal is open
	always_comb begin
		seq.is_end = (opcode == sle_pkg::OP_END);
		if (!lit_open) begin
			seq.chars[0] = sle_pkg::CH_DQUOTE;
			seq.chars[1] = body[0];
			seq.chars[2] = body[1];
			seq.chars[3] = body[2];
			seq.chars[4] = body[3];
			seq.count    = body_len + 3'd1;
		end else begin
			seq.chars[0] = body[0];
			seq.chars[1] = body[1];
			seq.chars[2] = body[2];
			seq.chars[3] = body[3];
			seq.chars[4] = 8'h00;
			seq.count    = body_len;
		end
	end

endmodule

/* hw/rtl/string_literal_escaper_unit.sv */
// Top level of the string literal escaper: request register, character
// shifter and output register. Depends on sle_pkg, sle_in_if, sle_out_if,
// sle_encoder.
//
//  channel | modport | payload                             | request carries
//  --------+---------+-------------------------------------+----------------------
//  item    | sink    | opcode, data_byte                   | one byte or end mark
//  text    | source  | out_char, run_last, literal_done    | one literal character
//
// A request is encoded as it is taken and emits 1 to 5 characters, one per
// cycle unless text stalls; a new request is taken in the cycle its
// predecessor's last character moves to the output register, so plain bytes
// stream at one per cycle unless text stalls; outputs are registered.
// arst_n clears the valid flags and closes any open literal.
// A stall on text holds the output register and, behind it, the request.
`timescale 1ns / 1ps

module string_literal_escaper_unit (
	input  logic      clk,
	input  logic      arst_n,
	sle_in_if.sink    item,
	sle_out_if.source text
);

	localparam int unsigned MaxChars = sle_pkg::MaxChars;

	sle_pkg::seq_t              seq;
	logic                       lit_open_q;
	logic                       valid_s1;
	sle_pkg::char_t [MaxChars-1:0] chars_s1;
	logic [sle_pkg::CountW-1:0] cnt_s1;
	logic                       end_s1;
	logic                       out_valid_q;
	sle_pkg::char_t             out_char_q;
	logic                       run_last_q;
	logic                       done_q;
	logic                       out_load;
	logic                       s1_last;
	logic                       accept;

	sle_encoder u_enc (
		.opcode    (item.opcode),
		.data_byte (item.data_byte),
		.lit_open  (lit_open_q),
		.seq       (seq)
	);

	// Handshake control
	assign s1_last    = (cnt_s1 == 3'd1);
	assign out_load   = valid_s1 && (!out_valid_q || text.ready);
	assign item.ready = !valid_s1 || (out_load && s1_last);
	assign accept     = item.valid && item.ready;

	// Literal open flag follows each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_open_q <= 1'b0;
		end else if (accept) begin
			lit_open_q <= (item.opcode == sle_pkg::OP_DATA);
		end
	end

	// Request stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_load && s1_last) begin
			valid_s1 <= 1'b0;
		end
	end

	// Character shifter: next character always at index 0
	always_ff @(posedge clk) begin
		if (accept) begin
			chars_s1 <= seq.chars;
			cnt_s1   <= seq.count;
			end_s1   <= seq.is_end;
		end else if (out_load) begin
			for (int i = 0; i < MaxChars - 1; i++) begin
				chars_s1[i] <= chars_s1[i+1];
			end
			chars_s1[MaxChars-1] <= 8'h00;
			cnt_s1 <= cnt_s1 - 3'd1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (text.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q <= chars_s1[0];
			run_last_q <= s1_last;
			done_q     <= s1_last && end_s1;
		end
	end

	assign text.valid        = out_valid_q;
	assign text.out_char     = out_char_q;
	assign text.run_last     = run_last_q;
	assign text.literal_done = done_q;

`ifndef NO_ASSERTIONS
	// The closing quote is always the last character of its request
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> run_last_q)
		else $error("literal_done without run_last");

	// A pending request always has characters left to send
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (cnt_s1 != 3'd0 && cnt_s1 <= 3'd5))
		else $error("request stage count out of range");

	// An end request closes the literal
	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.opcode == sle_pkg::OP_END |=> !lit_open_q && valid_s1)
		else $error("end request left literal open");

	// A data request leaves the literal open
	a_data_opens: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.opcode == sle_pkg::OP_DATA |=> lit_open_q && valid_s1)
		else $error("data request did not open literal");
`endif

endmodule

/* test/string_literal_escaper_unit_tb.sv */
// Testbench for string_literal_escaper_unit: random request and text stalls,
// inline prediction of the escaped literal, character-by-character checking.
// Depends on sle_pkg, sle_in_if, sle_out_if and the unit itself.
`timescale 1ns / 1ps

module string_literal_escaper_unit_tb;

	localparam int RandomItems = 460;
	localparam int CycleLimit  = 400000;
	localparam int MaxPrinted  = 40;

	typedef struct {
		logic       opcode;
		logic [7:0] data_byte;
	} req_t;

	typedef struct {
		sle_pkg::char_t out_char;
		logic           run_last;
		logic           literal_done;
	} lit_char_t;

	logic clk;
	logic arst_n;

	sle_in_if  item_ch ();
	sle_out_if text_ch ();

	string_literal_escaper_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.text   (text_ch)
	);

	req_t      pending_q[$];
	lit_char_t char_q[$];
	bit        literal_open;
	int        n_offered;
	int        n_accepted;
	int        n_errors;
	int        cycle_count;
	int        gap_left;
	int        item_calm;
	int        stall_left;
	int        text_calm;
	req_t      next_req;

	always #10 clk = ~clk;

	// One line per mismatch, capped so a broken build does not flood the log
	task automatic report(input string msg);
		if (n_errors < MaxPrinted) begin
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		end
		n_errors++;
	endtask

	// Gap length: mostly none or short, now and then long
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic sle_pkg::char_t hex_char(input logic [3:0] nib);
		sle_pkg::char_t c;
		if (nib < 4'd10) begin
			c = "0" + {4'd0, nib};
		end else begin
			c = "a" + {4'd0, nib} - 8'd10;
		end
		return c;
	endfunction

	// Expected characters for one accepted request
	task automatic predict_literal(input logic op, input logic [7:0] b);
		sle_pkg::char_t seq[5];
		int             n;
		sle_pkg::char_t letter;
		int             k;
		lit_char_t      lc;
		n = 0;
		letter = 8'd0;
		if (!literal_open) begin
			seq[n++] = sle_pkg::CH_DQUOTE;
			literal_open = 1'b1;
		end
		if (op == sle_pkg::OP_END) begin
			seq[n++] = sle_pkg::CH_DQUOTE;
			literal_open = 1'b0;
		end else begin
			case (b)
				sle_pkg::C_BEL: letter = "a";
				sle_pkg::C_BS:  letter = "b";
				sle_pkg::C_FF:  letter = "f";
				sle_pkg::C_LF:  letter = "n";
				sle_pkg::C_CR:  letter = "r";
				sle_pkg::C_TAB: letter = "t";
				sle_pkg::C_VT:  letter = "v";
				default: letter = 8'd0;
			endcase
			if (b == sle_pkg::CH_DQUOTE || b == sle_pkg::CH_SQUOTE ||
				b == sle_pkg::CH_BSLASH) begin
				seq[n++] = sle_pkg::CH_BSLASH;
				seq[n++] = b;
			end else if (letter != 8'd0) begin
				seq[n++] = sle_pkg::CH_BSLASH;
				seq[n++] = letter;
			end else if (b >= sle_pkg::FirstPrintable && b < sle_pkg::DelCode) begin
				seq[n++] = b;
			end else begin
				// control bytes, DEL and high bytes as unsigned hex
				seq[n++] = sle_pkg::CH_BSLASH;
				seq[n++] = sle_pkg::CH_X;
				seq[n++] = hex_char(b[7:4]);
				seq[n++] = hex_char(b[3:0]);
			end
		end
		for (k = 0; k < n; k++) begin
			lc.out_char     = seq[k];
			lc.run_last     = (k == n - 1);
			lc.literal_done = (k == n - 1) && (op == sle_pkg::OP_END);
			char_q.push_back(lc);
		end
	endtask

	task automatic add_request(input logic op, input logic [7:0] b);
		req_t r;
		r.opcode    = op;
		r.data_byte = b;
		pending_q.push_back(r);
	endtask

	// Byte mix weighted toward the interesting classes
	function automatic logic [7:0] draw_text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 8'($urandom_range(32, 126));
		if (r < 65) begin
			case ($urandom_range(0, 2))
				0: return sle_pkg::CH_DQUOTE;
				1: return sle_pkg::CH_SQUOTE;
				default: return sle_pkg::CH_BSLASH;
			endcase
		end
		if (r < 78) return 8'($urandom_range(0, 31));
		if (r < 85) return sle_pkg::DelCode;
		return 8'($urandom_range(128, 255));
	endfunction

	// Request driver: presents queued requests with random gaps
	always @(negedge clk) begin
		if (arst_n && (!item_ch.valid || n_accepted == n_offered)) begin
			if (gap_left > 0 || pending_q.size() == 0) begin
				item_ch.valid     <= 1'b0;
				item_ch.data_byte <= 8'($urandom);
				if (gap_left > 0) gap_left--;
			end else begin
				next_req = pending_q.pop_front();
				item_ch.valid     <= 1'b1;
				item_ch.opcode    <= next_req.opcode;
				item_ch.data_byte <= next_req.data_byte;
				n_offered++;
				if (item_calm > 0) begin
					item_calm--;
					gap_left = 0;
				end else begin
					if ($urandom_range(0, 99) < 5) item_calm = $urandom_range(20, 60);
					gap_left = draw_gap();
				end
			end
		end
	end

	// Text ready: random stalls with stall-free stretches
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				text_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				text_ch.ready <= 1'b1;
				if (text_calm > 0) begin
					text_calm--;
				end else if ($urandom_range(0, 99) < 4) begin
					text_calm = $urandom_range(20, 80);
				end else if ($urandom_range(0, 99) < 30) begin
					stall_left = draw_gap();
				end
			end
		end
	end

	// Monitor: predict on accepted requests, check accepted characters
	always @(posedge clk) begin
		lit_char_t want;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				predict_literal(item_ch.opcode, item_ch.data_byte);
				n_accepted++;
			end
			if (text_ch.valid && text_ch.ready) begin
				if (char_q.size() == 0) begin
					report($sformatf("unexpected char 0x%02h", text_ch.out_char));
				end else begin
					want = char_q.pop_front();
					if (text_ch.out_char !== want.out_char)
						report($sformatf("out_char 0x%02h, wanted 0x%02h",
							text_ch.out_char, want.out_char));
					if (text_ch.run_last !== want.run_last)
						report($sformatf("run_last %b, wanted %b",
							text_ch.run_last, want.run_last));
					if (text_ch.literal_done !== want.literal_done)
						report($sformatf("literal_done %b, wanted %b",
							text_ch.literal_done, want.literal_done));
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int total;
		int r;
		int len;
		int k;
		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.opcode = sle_pkg::OP_DATA;
		item_ch.data_byte = 8'd0;
		text_ch.ready = 1'b0;
		literal_open = 1'b0;
		n_offered = 0;
		n_accepted = 0;
		n_errors = 0;
		cycle_count = 0;
		gap_left = 0;
		item_calm = 0;
		stall_left = 0;
		text_calm = 0;

		// Directed: empty string, zero byte, high bytes, DEL, printable edges,
		// escaped quotes and backslash, every letter escape, ignored data on end
		add_request(sle_pkg::OP_END, 8'h00);
		add_request(sle_pkg::OP_DATA, 8'h00);
		add_request(sle_pkg::OP_DATA, 8'hff);
		add_request(sle_pkg::OP_DATA, 8'h80);
		add_request(sle_pkg::OP_DATA, sle_pkg::DelCode);
		add_request(sle_pkg::OP_DATA, 8'h1f);
		add_request(sle_pkg::OP_DATA, sle_pkg::FirstPrintable);
		add_request(sle_pkg::OP_DATA, 8'h7e);
		add_request(sle_pkg::OP_DATA, sle_pkg::CH_DQUOTE);
		add_request(sle_pkg::OP_DATA, sle_pkg::CH_SQUOTE);
		add_request(sle_pkg::OP_DATA, sle_pkg::CH_BSLASH);
		add_request(sle_pkg::OP_DATA, 8'h06);
		for (k = 7; k <= 13; k++) add_request(sle_pkg::OP_DATA, 8'(k));
		add_request(sle_pkg::OP_DATA, 8'h0e);
		add_request(sle_pkg::OP_END, 8'ha5);
		add_request(sle_pkg::OP_DATA, 8'h41);
		add_request(sle_pkg::OP_END, 8'hff);
		add_request(sle_pkg::OP_END, 8'h5a);

		// Random: mostly whole strings, some raw noise requests
		total = pending_q.size() + RandomItems;
		while (pending_q.size() < total) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				add_request(1'($urandom_range(0, 1)), 8'($urandom));
			end else begin
				len = (r < 90) ? $urandom_range(0, 8) : $urandom_range(9, 40);
				for (k = 0; k < len; k++) add_request(sle_pkg::OP_DATA, draw_text_byte());
				add_request(sle_pkg::OP_END, 8'($urandom));
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || n_accepted != n_offered) @(posedge clk);
		while (char_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (char_q.size() != 0) report($sformatf("%0d chars never arrived", char_q.size()));

		if (n_errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/sle_pkg.sv
hw/rtl/sle_in_if.sv
hw/rtl/sle_out_if.sv
hw/rtl/sle_encoder.sv
hw/rtl/string_literal_escaper_unit.sv
test/string_literal_escaper_unit_tb.sv
